// File: design/srd_pkg.sv
package srd_pkg;

  localparam logic [31:0] MAGIC_WORD        = 32'h0000_0002;
  localparam logic [7:0]  SKIP_BASE         = 8'h80;
  localparam logic [7:0]  CLEAR_PIXEL       = 8'hFF;
  localparam logic [31:0] MAX_PIXELS_RESET  = 32'd64000;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pixel_value;
    logic [6:0]  run_length;
    logic [15:0] width;
    logic [15:0] height;
    logic        last;
  } result_t;

endpackage

// File: design/srd_if.sv
interface srd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       image_start;

  modport source (output valid, output code_byte, output image_start, input ready);
  modport sink   (input valid, input code_byte, input image_start, output ready);
endinterface

interface srd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  pixel_value;
  logic [6:0]  run_length;
  logic [15:0] width;
  logic [15:0] height;
  logic        last;

  modport source (output valid, output kind, output pixel_value, output run_length,
                  output width, output height, output last, input ready);
  modport sink   (input valid, input kind, input pixel_value, input run_length,
                  input width, input height, input last, output ready);
endinterface

interface srd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] max_pixels;

  modport source (output valid, output max_pixels, input ready);
  modport sink   (input valid, input max_pixels, output ready);
endinterface

// File: design/srd_parser.sv
module srd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          code_byte_i,
  input  logic                image_start_i,
  input  logic [31:0]         max_pixels_i,
  output logic                res_valid_o,
  output srd_pkg::result_t    res_o
);
  import srd_pkg::*;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_CONTROL = 3'd1;
  localparam logic [2:0] PH_LITERAL = 3'd2;
  localparam logic [2:0] PH_DROP    = 3'd3;
  localparam logic [2:0] PH_ERROR   = 3'd4;

  localparam logic [1:0] HDR_LAST = 2'd3;
  localparam logic [1:0] HDR_H_LO = 2'd2;

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic        magic_q, magic_d;
  logic [7:0]  hb0_q, hb0_d, hb1_q, hb1_d, hb2_q, hb2_d;
  logic [15:0] width_q, width_d;
  logic [23:0] prod_q, prod_d;
  logic [31:0] remain_q, remain_d;
  logic [7:0]  left_q, left_d;

  logic [2:0]  ph;
  logic [1:0]  cnt;
  logic        magic;
  logic [15:0] hdr_w, hdr_h;
  logic [23:0] mul;
  logic [31:0] total;
  logic [6:0]  skip_n, skip_clip;
  logic        is_skip, skip_last;

  always_comb begin
    ph        = image_start_i ? PH_HEADER : phase_q;
    cnt       = image_start_i ? 2'd0 : hcnt_q;
    magic     = image_start_i ? 1'b0 : magic_q;
    hdr_w     = {hb1_q, hb0_q};
    hdr_h     = {code_byte_i, hb2_q};
    mul       = {8'd0, hdr_w} * {16'd0, code_byte_i};
    total     = {8'd0, prod_q} + {mul, 8'd0};
    skip_n    = code_byte_i[6:0];
    is_skip   = code_byte_i[7] && (skip_n != 7'd0) && ({9'd0, skip_n} <= width_q);
    skip_last = remain_q <= {25'd0, skip_n};
    skip_clip = skip_last ? remain_q[6:0] : skip_n;
  end

  always_comb begin
    phase_d     = phase_q;
    hcnt_d      = hcnt_q;
    magic_d     = magic_q;
    hb0_d       = hb0_q;
    hb1_d       = hb1_q;
    hb2_d       = hb2_q;
    width_d     = width_q;
    prod_d      = prod_q;
    remain_d    = remain_q;
    left_d      = left_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      unique case (ph)
        PH_HEADER: begin
          phase_d = PH_HEADER;
          if (cnt != HDR_LAST) begin
            unique case (cnt)
              2'd0:    hb0_d = code_byte_i;
              2'd1:    hb1_d = code_byte_i;
              default: hb2_d = code_byte_i;
            endcase
            if (cnt == HDR_H_LO) begin
              prod_d = mul;
            end
            hcnt_d  = cnt + 2'd1;
            magic_d = magic;
          end else begin
            hcnt_d = 2'd0;
            if (!magic && ({code_byte_i, hb2_q, hb1_q, hb0_q} == MAGIC_WORD)) begin
              magic_d = 1'b1;
            end else begin
              magic_d      = 1'b0;
              width_d      = hdr_w;
              res_valid_o  = 1'b1;
              res_o.width  = hdr_w;
              res_o.height = hdr_h;
              if (total > max_pixels_i) begin
                phase_d    = PH_ERROR;
                res_o.kind = KIND_ERROR;
              end else if (total == 32'd0) begin
                res_o.kind = KIND_HEADER;
                res_o.last = 1'b1;
              end else begin
                phase_d    = PH_CONTROL;
                remain_d   = total;
                res_o.kind = KIND_HEADER;
              end
            end
          end
        end
        PH_CONTROL: begin
          if (is_skip) begin
            remain_d          = remain_q - {25'd0, skip_clip};
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_PIXEL;
            res_o.pixel_value = CLEAR_PIXEL;
            res_o.run_length  = skip_clip;
            res_o.last        = skip_last;
            if (skip_last) begin
              phase_d = PH_HEADER;
            end
          end else if (code_byte_i != 8'd0) begin
            left_d  = code_byte_i;
            phase_d = PH_LITERAL;
          end
        end
        PH_LITERAL: begin
          left_d            = left_q - 8'd1;
          remain_d          = remain_q - 32'd1;
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_PIXEL;
          res_o.pixel_value = code_byte_i;
          res_o.run_length  = 7'd1;
          res_o.last        = remain_q == 32'd1;
          if (remain_q == 32'd1) begin
            phase_d = (left_d != 8'd0) ? PH_DROP : PH_HEADER;
          end else if (left_d == 8'd0) begin
            phase_d = PH_CONTROL;
          end
        end
        PH_DROP: begin
          left_d = left_q - 8'd1;
          if (left_d == 8'd0) begin
            phase_d = PH_HEADER;
          end
        end
        PH_ERROR: begin
          phase_d = PH_ERROR;
        end
        default: begin
          phase_d = PH_HEADER;
          hcnt_d  = 2'd0;
          magic_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      hcnt_q   <= 2'd0;
      magic_q  <= 1'b0;
      width_q  <= 16'd0;
      remain_q <= 32'd0;
      left_q   <= 8'd0;
    end else begin
      phase_q  <= phase_d;
      hcnt_q   <= hcnt_d;
      magic_q  <= magic_d;
      width_q  <= width_d;
      remain_q <= remain_d;
      left_q   <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hb0_q  <= hb0_d;
    hb1_q  <= hb1_d;
    hb2_q  <= hb2_d;
    prod_q <= prod_d;
  end

endmodule

// File: design/srd_out_skid.sv
module srd_out_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  srd_pkg::result_t  res_i,
  output logic              ready_o,
  srd_out_if.source         out_o
);
  import srd_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_free;

  assign ready_o  = !skid_valid_q;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_valid_i;
        out_d       = res_i;
      end
    end else if (res_valid_i) begin
      skid_valid_d = 1'b1;
      skid_d       = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.pixel_value = out_q.pixel_value;
  assign out_o.run_length  = out_q.run_length;
  assign out_o.width       = out_q.width;
  assign out_o.height      = out_q.height;
  assign out_o.last        = out_q.last;

endmodule

// File: design/sprite_rle_decoder_core.sv
// Run-length sprite decoder, one code byte per transaction.
// A result is registered at the output when its byte is taken, or in skid on a stall.
// Throughput: one byte per cycle through a single registered pass; a result-side
// stall fills the skid register and holds the input off until it drains.
// Reset (async, active low): header parsing, empty output, max_pixels = 64000.
module sprite_rle_decoder_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  srd_in_if.sink    in_i,
  srd_out_if.source out_o,
  srd_cfg_if.sink   cfg_i
);
  import srd_pkg::*;

  logic [31:0] max_pixels_q;
  logic        accept;
  logic        res_valid;
  logic        skid_ready;
  result_t     res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pixels_q <= MAX_PIXELS_RESET;
    end else if (cfg_i.valid) begin
      max_pixels_q <= cfg_i.max_pixels;
    end
  end

  assign in_i.ready = skid_ready;
  assign accept     = in_i.valid && skid_ready;

  srd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .code_byte_i   (in_i.code_byte),
    .image_start_i (in_i.image_start),
    .max_pixels_i  (max_pixels_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  srd_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (skid_ready),
    .out_o       (out_o)
  );

endmodule

// File: test/sprite_rle_decoder_core_test.sv
`timescale 1ns / 100ps

module sprite_rle_decoder_core_test;
  import srd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_CONTROL,
    ST_LITERAL,
    ST_DROP,
    ST_ERROR
  } dec_state_e;

  typedef struct {
    logic [7:0] code;
    logic       start;
  } code_item_t;

  typedef logic [7:0] byte_list_t [$];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  srd_in_if  in_bus ();
  srd_out_if out_bus ();
  srd_cfg_if cfg_bus ();

  sprite_rle_decoder_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  always #10 clk_i = ~clk_i;

  // decoder shadow state
  dec_state_e  dec_state = ST_HEADER;
  logic [31:0] hdr_bytes = '0;
  logic [2:0]  hdr_count = '0;
  logic        magic_seen = 1'b0;
  logic [15:0] img_width = '0;
  logic [31:0] pix_total = '0;
  logic [31:0] pix_pos = '0;
  logic [7:0]  lit_left = '0;
  logic [31:0] capacity = MAX_PIXELS_RESET;

  code_item_t byte_queue [$];
  result_t    decoded_q [$];
  code_item_t nxt;
  result_t    res_next;

  int unsigned errors = 0;
  int unsigned items_queued = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned images_built = 0;
  int unsigned cap_settings = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  logic [5:0]  stall_tick = '0;
  logic [7:0]  stall_mask = 8'hFF;
  bit          clean = 1'b1;

  function automatic void restart_header();
    dec_state  = ST_HEADER;
    hdr_bytes  = '0;
    hdr_count  = '0;
    magic_seen = 1'b0;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                     output result_t r);
    logic [31:0] remain;
    logic [31:0] n;
    r = '0;
    if (start) restart_header();
    case (dec_state)
      ST_HEADER: begin
        hdr_bytes = hdr_bytes | (32'(b) << (8 * hdr_count[1:0]));
        hdr_count = hdr_count + 3'd1;
        if (hdr_count < 3'd4) return 1'b0;
        if (!magic_seen && hdr_bytes == MAGIC_WORD) begin
          magic_seen = 1'b1;
          hdr_bytes  = '0;
          hdr_count  = '0;
          return 1'b0;
        end
        img_width  = hdr_bytes[15:0];
        pix_total  = 32'(hdr_bytes[15:0]) * 32'(hdr_bytes[31:16]);
        r.width    = hdr_bytes[15:0];
        r.height   = hdr_bytes[31:16];
        pix_pos    = '0;
        lit_left   = '0;
        hdr_bytes  = '0;
        hdr_count  = '0;
        magic_seen = 1'b0;
        if (pix_total > capacity) begin
          dec_state = ST_ERROR;
          r.kind    = KIND_ERROR;
          return 1'b1;
        end
        r.kind = KIND_HEADER;
        if (pix_total == 0) begin
          restart_header();
          r.last = 1'b1;
        end else begin
          dec_state = ST_CONTROL;
        end
        return 1'b1;
      end
      ST_CONTROL: begin
        remain = pix_total - pix_pos;
        if (b > SKIP_BASE && 32'(b) <= 32'(SKIP_BASE) + 32'(img_width)) begin
          n = 32'(b - SKIP_BASE);
          if (n > remain) n = remain;
          pix_pos       = pix_pos + n;
          r.kind        = KIND_PIXEL;
          r.pixel_value = CLEAR_PIXEL;
          r.run_length  = n[6:0];
          r.last        = (pix_pos >= pix_total);
          if (r.last) restart_header();
          return 1'b1;
        end
        if (b != 8'd0) begin
          lit_left  = b;
          dec_state = ST_LITERAL;
        end
        return 1'b0;
      end
      ST_LITERAL: begin
        lit_left      = lit_left - 8'd1;
        pix_pos       = pix_pos + 32'd1;
        r.kind        = KIND_PIXEL;
        r.pixel_value = b;
        r.run_length  = 7'd1;
        r.last        = (pix_pos >= pix_total);
        if (r.last) begin
          if (lit_left != 8'd0) dec_state = ST_DROP;
          else restart_header();
        end else if (lit_left == 8'd0) begin
          dec_state = ST_CONTROL;
        end
        return 1'b1;
      end
      ST_DROP: begin
        lit_left = lit_left - 8'd1;
        if (lit_left == 8'd0) restart_header();
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= 100) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic check_result(input result_t want);
    if (out_bus.kind !== want.kind)
      flag_mismatch($sformatf("result %0d kind %0d, expected %0d",
                              results_seen, out_bus.kind, want.kind));
    if (out_bus.pixel_value !== want.pixel_value)
      flag_mismatch($sformatf("result %0d pixel_value %0h, expected %0h",
                              results_seen, out_bus.pixel_value, want.pixel_value));
    if (out_bus.run_length !== want.run_length)
      flag_mismatch($sformatf("result %0d run_length %0d, expected %0d",
                              results_seen, out_bus.run_length, want.run_length));
    if (out_bus.width !== want.width)
      flag_mismatch($sformatf("result %0d width %0d, expected %0d",
                              results_seen, out_bus.width, want.width));
    if (out_bus.height !== want.height)
      flag_mismatch($sformatf("result %0d height %0d, expected %0d",
                              results_seen, out_bus.height, want.height));
    if (out_bus.last !== want.last)
      flag_mismatch($sformatf("result %0d last %0b, expected %0b",
                              results_seen, out_bus.last, want.last));
  endtask

  // driver: bursts with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        items_sent++;
        if (decode_byte(in_bus.code_byte, in_bus.image_start, res_next))
          decoded_q.push_back(res_next);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left != 0 || byte_queue.size() == 0) begin
          in_bus.valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          nxt = byte_queue.pop_front();
          in_bus.valid       <= 1'b1;
          in_bus.code_byte   <= nxt.code;
          in_bus.image_start <= nxt.start;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // monitor and result-side stall pattern
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (decoded_q.size() == 0)
          flag_mismatch($sformatf("result %0d arrived with none expected", results_seen));
        else
          check_result(decoded_q.pop_front());
        results_seen++;
      end
      if (stall_tick == 6'd0) begin
        case ($urandom_range(0, 3))
          0:       stall_mask = 8'hFF;
          1:       stall_mask = 8'($urandom());
          default: stall_mask = 8'($urandom()) | 8'($urandom());
        endcase
      end
      out_bus.ready <= stall_mask[stall_tick[2:0]];
      stall_tick = stall_tick + 6'd1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, decoded_q.size());
      $display("sprite_rle_decoder_core_test: done, errors");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] code, input logic start);
    code_item_t it;
    it.code  = code;
    it.start = start;
    byte_queue.push_back(it);
    items_queued++;
  endtask

  task automatic push_run(input byte_list_t seq, input bit start);
    foreach (seq[i]) push_byte(seq[i], (i == 0) ? start : 1'b0);
  endtask

  task automatic push_header(input int w, input int h, input bit st, input bit mg);
    if (mg) begin
      push_byte(MAGIC_WORD[7:0], st);
      push_byte(MAGIC_WORD[15:8], 1'b0);
      push_byte(MAGIC_WORD[23:16], 1'b0);
      push_byte(MAGIC_WORD[31:24], 1'b0);
      st = 1'b0;
    end
    push_byte(w[7:0], st);
    push_byte(w[15:8], 1'b0);
    push_byte(h[7:0], 1'b0);
    push_byte(h[15:8], 1'b0);
  endtask

  task automatic push_literal(input int cnt, inout longint rem, inout int budget);
    push_byte(8'(cnt), 1'b0);
    repeat (cnt) push_byte(8'($urandom_range(0, 255)), 1'b0);
    rem    = rem - ((cnt > rem) ? rem : cnt);
    budget = budget - cnt - 1;
  endtask

  task automatic push_body(input int w, input longint total, input int budget,
                           output bit done);
    longint rem;
    int     k;
    int     n;
    rem = total;
    while (rem > 0 && budget > 0) begin
      k = $urandom_range(0, 59);
      if (k < 3) begin
        push_byte(8'd0, 1'b0);
        budget--;
      end else if (k < 25) begin
        n = $urandom_range(1, (w > 127) ? 127 : w);
        push_byte(8'(SKIP_BASE + n), 1'b0);
        rem = rem - ((n > rem) ? rem : n);
        budget--;
      end else if (k == 59 && w < 127) begin
        push_literal($urandom_range(SKIP_BASE + w + 1, 255), rem, budget);
      end else begin
        push_literal($urandom_range(1, (rem + 2 > 16) ? 16 : int'(rem) + 2), rem, budget);
      end
    end
    done = (rem == 0);
  endtask

  task automatic build_image();
    int     w;
    int     h;
    int     k;
    int     budget;
    longint total;
    bit     st;
    bit     done;
    k  = $urandom_range(0, 19);
    st = clean ? ($urandom_range(0, 6) != 0) : 1'b1;
    images_built++;
    if (k == 0) begin
      repeat ($urandom_range(1, 10))
        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      clean = 1'b0;
      return;
    end
    if (k == 1) begin
      w = $urandom_range(0, 65535);
      h = $urandom_range(0, 65535);
    end else if (k == 2) begin
      w = $urandom_range(100, 200);
      h = $urandom_range(1, 2);
    end else if (k == 3) begin
      w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 65535);
      h = (w == 0) ? $urandom_range(0, 65535) : 0;
    end else begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
    end
    push_header(w, h, st, $urandom_range(0, 3) == 0);
    total = longint'(w) * longint'(h);
    if (total > capacity) begin
      repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      clean = 1'b0;
      return;
    end
    if (total == 0) begin
      clean = 1'b1;
      return;
    end
    if (total > 2000) budget = $urandom_range(1, 12);
    else if ($urandom_range(0, 7) == 0) budget = $urandom_range(1, int'(total));
    else budget = 1000000;
    push_body(w, total, budget, done);
    clean = done;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (byte_queue.size() != 0 || in_bus.valid || decoded_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [31:0] value);
    @(posedge clk_i);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.max_pixels <= value;
    do @(posedge clk_i);
    while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    capacity = value;
    cap_settings++;
  endtask

  initial begin
    logic [31:0] cap_list [7];
    int unsigned target;

    in_bus.valid       = 1'b0;
    in_bus.code_byte   = 8'd0;
    in_bus.image_start = 1'b0;
    out_bus.ready      = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.max_pixels = 32'd0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // magic twice: second one is a 2x0 header, empty image
    push_run('{8'h02, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00}, 1'b1);
    // 2x2 with no start mark, zero control, skip, literal pair, clipped skip
    push_run('{8'h02, 8'h00, 8'h02, 8'h00, 8'h00, 8'h81, 8'h02, 8'h00, 8'hFF, 8'h82},
             1'b0);
    // oversize under the reset capacity, trailing byte ignored
    push_run('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h81}, 1'b1);
    // 1x1 with literal bytes past the end
    push_run('{8'h01, 8'h00, 8'h01, 8'h00, 8'h03, 8'hAA, 8'h55, 8'h77}, 1'b1);
    images_built += 4;

    cap_list = '{32'd0, 32'hFFFF_FFFF, 32'd20, MAX_PIXELS_RESET, 32'd1, 32'd48,
                 32'($urandom_range(8, 80))};
    foreach (cap_list[i]) begin
      wait_idle();
      write_capacity(cap_list[i]);
      target = items_queued + 85;
      while (items_queued < target) build_image();
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("covered %0d code bytes in %0d images under %0d capacity settings, %0d results",
             items_sent, images_built, cap_settings, results_seen);
    if (errors == 0) begin
      $display("sprite_rle_decoder_core_test: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("sprite_rle_decoder_core_test: done, errors");
    end
    $finish;
  end

endmodule
